### hdl/gdfw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdfw_pkg
// Shared constants and controller command word for the depth-first walk unit.
// ----------------------------------------------------------------------------
package gdfw_pkg;

  localparam int NODE_COUNT_DEFAULT = 8;
  localparam int NODE_FIELD_W       = 3;
  localparam int FIELD_NODES        = 2 ** NODE_FIELD_W;

  typedef struct packed {
    logic load;    // input word accepted
    logic init;    // accepted word closes the graph, set up the walk
    logic step;    // one walk step
    logic finish;  // emit final result, clear graph
  } gdfw_cmd_t;

endpackage

`default_nettype wire

### hdl/gdfw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdfw_ctrl
// Controller: sequences edge loading, the walk and the final result.
// ----------------------------------------------------------------------------
module gdfw_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               graph_done,
  input  wire logic               walk_end,
  output logic                    busy,
  output gdfw_pkg::gdfw_cmd_t     cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_WALK   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign busy       = (state != ST_IDLE);
  assign cmd.load   = start && (state == ST_IDLE);
  assign cmd.init   = cmd.load && graph_done;
  assign cmd.step   = (state == ST_WALK);
  assign cmd.finish = (state == ST_FINISH);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.init) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (walk_end) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### hdl/gdfw_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdfw_datapath
// Adjacency matrix, visited marks, frame stack, scan registers and the
// one-deep result holding register that lets the final result be marked.
// ----------------------------------------------------------------------------
module gdfw_datapath #(
  parameter int NODE_COUNT = gdfw_pkg::NODE_COUNT_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire gdfw_pkg::gdfw_cmd_t                cmd,
  input  wire logic [gdfw_pkg::NODE_FIELD_W-1:0]  from_node,
  input  wire logic [gdfw_pkg::NODE_FIELD_W-1:0]  to_node,
  input  wire logic                               add_edge,
  output logic                                    walk_end,
  output logic                                    result_valid,
  output logic [gdfw_pkg::NODE_FIELD_W-1:0]       parent_node,
  output logic [gdfw_pkg::NODE_FIELD_W-1:0]       child_node,
  output logic                                    edge_found,
  output logic                                    last_result
);

  // only nodes reachable by the 3-bit fields can carry edges
  localparam int ROW_NODES = (NODE_COUNT < gdfw_pkg::FIELD_NODES) ?
                             NODE_COUNT : gdfw_pkg::FIELD_NODES;
  localparam int NODE_W    = $clog2(ROW_NODES);
  localparam int SCAN_W    = $clog2(ROW_NODES + 1);
  localparam int LIM_W     = gdfw_pkg::NODE_FIELD_W + 1;

  localparam logic [LIM_W-1:0]  ROW_LIM   = LIM_W'(ROW_NODES);
  localparam logic [SCAN_W-1:0] SCAN_END  = SCAN_W'(ROW_NODES);
  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(ROW_NODES - 1);

  logic [ROW_NODES-1:0] adj [ROW_NODES];
  logic [ROW_NODES-1:0] visited;
  logic [NODE_W-1:0]    stack_node [ROW_NODES];
  logic [SCAN_W-1:0]    stack_scan [ROW_NODES];
  logic [SCAN_W-1:0]    depth;
  logic [NODE_W-1:0]    start_n;
  logic [NODE_W-1:0]    cur_node;
  logic [SCAN_W-1:0]    cur_j;
  logic                 pend_valid;
  logic [NODE_W-1:0]    pend_parent;
  logic [NODE_W-1:0]    pend_child;

  logic                 edge_ok;
  logic                 scan_done;
  logic [NODE_W-1:0]    j_idx;
  logic                 hit;
  logic [SCAN_W-1:0]    depth_m1;

  assign edge_ok   = add_edge && ({1'b0, from_node} < ROW_LIM) &&
                     ({1'b0, to_node} < ROW_LIM);
  assign scan_done = (cur_j == SCAN_END);
  assign j_idx     = cur_j[NODE_W-1:0];
  assign hit       = !scan_done && adj[cur_node][j_idx] && !visited[j_idx];
  assign depth_m1  = depth - 1'b1;
  assign walk_end  = cmd.step && scan_done && (depth == '0) && (start_n == LAST_NODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROW_NODES; i++) adj[i] <= '0;
      visited      <= '0;
      depth        <= '0;
      start_n      <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cmd.load) begin
        if (edge_ok) adj[from_node[NODE_W-1:0]][to_node[NODE_W-1:0]] <= 1'b1;
        if (cmd.init) begin
          start_n    <= '0;
          cur_node   <= '0;
          cur_j      <= '0;
          depth      <= '0;
          pend_valid <= 1'b0;
        end
      end else if (cmd.step) begin
        if (hit) begin
          visited[j_idx] <= 1'b1;
          stack_node[depth[NODE_W-1:0]] <= cur_node;
          stack_scan[depth[NODE_W-1:0]] <= cur_j + 1'b1;
          depth    <= depth + 1'b1;
          cur_node <= j_idx;
          cur_j    <= '0;
          // previous tree edge is known not to be last now
          if (pend_valid) begin
            result_valid <= 1'b1;
            parent_node  <= gdfw_pkg::NODE_FIELD_W'(pend_parent);
            child_node   <= gdfw_pkg::NODE_FIELD_W'(pend_child);
            edge_found   <= 1'b1;
            last_result  <= 1'b0;
          end
          pend_valid  <= 1'b1;
          pend_parent <= cur_node;
          pend_child  <= j_idx;
        end else if (!scan_done) begin
          cur_j <= cur_j + 1'b1;
        end else if (depth != '0) begin
          cur_node <= stack_node[depth_m1[NODE_W-1:0]];
          cur_j    <= stack_scan[depth_m1[NODE_W-1:0]];
          depth    <= depth_m1;
        end else if (start_n != LAST_NODE) begin
          start_n  <= start_n + 1'b1;
          cur_node <= start_n + 1'b1;
          cur_j    <= '0;
        end
      end else if (cmd.finish) begin
        result_valid <= 1'b1;
        parent_node  <= pend_valid ? gdfw_pkg::NODE_FIELD_W'(pend_parent) : '0;
        child_node   <= pend_valid ? gdfw_pkg::NODE_FIELD_W'(pend_child) : '0;
        edge_found   <= pend_valid;
        last_result  <= 1'b1;
        pend_valid   <= 1'b0;
        for (int i = 0; i < ROW_NODES; i++) adj[i] <= '0;
        visited      <= '0;
        depth        <= '0;
        start_n      <= '0;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/graph_depth_first_walk_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// graph_depth_first_walk_unit
// Depth-first walk over a directed graph held as an adjacency bit matrix.
// ----------------------------------------------------------------------------
// Each input word is taken when start is high and busy is low, one per cycle,
// and records the edge from_node -> to_node when add_edge is set. The word with
// graph_done set ends the graph: busy rises and the walk runs from every start
// node in ascending order, one neighbor scan position or one stack pop per
// cycle. Each tree edge comes out as one result word with result_valid high
// for exactly one cycle; the receiver cannot stall, so it must take every word
// in the cycle it is shown. Results trail discovery by one tree edge so that
// the final one carries last_result; an empty walk gives one word with
// edge_found low. The graph clears when the walk ends.
// ----------------------------------------------------------------------------
module graph_depth_first_walk_unit #(
  parameter int NODE_COUNT = gdfw_pkg::NODE_COUNT_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [gdfw_pkg::NODE_FIELD_W-1:0]  from_node,
  input  wire logic [gdfw_pkg::NODE_FIELD_W-1:0]  to_node,
  input  wire logic                               add_edge,
  input  wire logic                               graph_done,
  output logic                                    result_valid,
  output logic [gdfw_pkg::NODE_FIELD_W-1:0]       parent_node,
  output logic [gdfw_pkg::NODE_FIELD_W-1:0]       child_node,
  output logic                                    edge_found,
  output logic                                    last_result
);

  gdfw_pkg::gdfw_cmd_t cmd;
  logic                walk_end;

  gdfw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .graph_done (graph_done),
    .walk_end   (walk_end),
    .busy       (busy),
    .cmd        (cmd)
  );

  gdfw_datapath #(
    .NODE_COUNT (NODE_COUNT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .from_node    (from_node),
    .to_node      (to_node),
    .add_edge     (add_edge),
    .walk_end     (walk_end),
    .result_valid (result_valid),
    .parent_node  (parent_node),
    .child_node   (child_node),
    .edge_found   (edge_found),
    .last_result  (last_result)
  );

endmodule

`default_nettype wire
